// File: design/swwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swwl_pkg: shared types and constants of the sliding window weight limiter
// Holds the request/result field widths, status codes, register indexes,
// the controller state encoding and the log entry layout.
// ----------------------------------------------------------------------------
package swwl_pkg;

  // field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WeightW = 8;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned ShownW  = 14;
  localparam int unsigned StatusW = 2;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgWeightLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowTicks = 2'd1;

  // reset values of the registers
  localparam logic [LimitW-1:0] LimitReset  = 16'd100;
  localparam logic [TimeW-1:0]  WindowReset = 32'd60;

  // largest total shown on the result
  localparam logic [ShownW-1:0] ShownMax = 14'h3FFF;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatusAccepted  = 2'd0,
    StatusOverLimit = 2'd1,
    StatusLogFull   = 2'd2
  } status_e;

  // controller states, one-hot
  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StCheck = 2'b10
  } state_e;

  // one log entry as held in the ring memory
  typedef struct packed {
    logic [TimeW-1:0]   stamp;
    logic [WeightW-1:0] weight;
  } log_entry_t;

  // write request into the ring memory
  typedef struct packed {
    logic       en;
    log_entry_t entry;
  } log_wr_t;

endpackage

// File: design/swwl_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swwl_log: ring memory of logged requests
// Single write port and one synchronous read port.
// ----------------------------------------------------------------------------
module swwl_log #(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic [$clog2(LOG_DEPTH)-1:0]  rd_addr_i,
  output swwl_pkg::log_entry_t          rd_data_o,
  input  logic [$clog2(LOG_DEPTH)-1:0]  wr_addr_i,
  input  swwl_pkg::log_wr_t             wr_i
);

  swwl_pkg::log_entry_t mem_q [LOG_DEPTH];
  swwl_pkg::log_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.entry;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/sliding_window_weight_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_weight_limiter: admits weighted requests within a time window
// Keeps a ring log of admitted requests and refuses those that would push the
// windowed weight total past the limit or that find the log full.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries a request: tdata = {weight, now_time}. m_axis returns one
//   result per request: tdata = {window_total, status, accepted}.
//   The cfg channel writes weight_limit (index 0) or window_ticks (index 1);
//   write it only while no request is in flight. Other indexes are ignored.
// Sequencing:
//   after a request is accepted, the check step expires log entries from the
//   head one by one and then loads the result. Each expiry costs one read of
//   the ring memory, whose read port pops one head entry per cycle. The next
//   request is taken once the result is loaded, so a new request is not
//   accepted while the previous one is still in its check step.
// Reset:
//   the log is empty, the total is zero, limit 100, window 60 ticks. The ring
//   memory itself is not cleared; only entries inside the live region are used.
// Stalls:
//   the result waits in an output register; a new request is accepted while
//   it waits, and the block holds in its check step until the register frees.
// ----------------------------------------------------------------------------
module sliding_window_weight_limiter #(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request: [31:0] now_time, [39:32] weight
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [swwl_pkg::InDataW-1:0]      s_axis_tdata,
  // result: [0] accepted, [2:1] status, [16:3] window_total, [23:17] zero
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [swwl_pkg::OutDataW-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swwl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [swwl_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned PtrW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(LOG_DEPTH + 1);
  localparam int unsigned TotalW = $clog2(LOG_DEPTH * 255 + 1);
  localparam int unsigned CmpW   = (TotalW + 1 > 17) ? TotalW + 1 : 17;
  localparam int unsigned SumW   = CntW + 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(LOG_DEPTH - 1);

  // registers
  swwl_pkg::state_e                   state_q, state_d;
  logic [swwl_pkg::LimitW-1:0]        limit_q;
  logic [swwl_pkg::TimeW-1:0]         window_q;
  logic [PtrW-1:0]                    head_q, head_d;
  logic [CntW-1:0]                    count_q, count_d;
  logic [TotalW-1:0]                  total_q, total_d;
  logic [swwl_pkg::TimeW-1:0]         now_q;
  logic [swwl_pkg::WeightW-1:0]       weight_q;
  logic                               out_valid_q, out_valid_d;
  logic [swwl_pkg::OutDataW-1:0]      out_data_q, out_data_d;

  // datapath
  swwl_pkg::log_entry_t               rd_entry;
  swwl_pkg::log_wr_t                  wr_req;
  logic [PtrW-1:0]                    tail_idx;
  logic [SumW-1:0]                    tail_sum;
  logic [swwl_pkg::TimeW-1:0]         age;
  logic                               expire;
  logic                               out_free;
  logic [CmpW-1:0]                    sum_w;
  logic [CmpW-1:0]                    result_total;
  logic                               over_limit;
  logic                               log_full;
  logic                               admit;
  swwl_pkg::status_e                  status;
  logic [swwl_pkg::ShownW-1:0]        shown;
  logic                               in_req;

  assign s_axis_tready = (state_q == swwl_pkg::StIdle);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // ring memory, read at the next head so a pop can chain every cycle
  swwl_log #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_log (
    .clk_i     (clk_i),
    .rd_addr_i (head_d),
    .rd_data_o (rd_entry),
    .wr_addr_i (tail_idx),
    .wr_i      (wr_req)
  );

  // tail position, head plus count wrapped once
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= SumW'(LOG_DEPTH)) ? PtrW'(tail_sum - SumW'(LOG_DEPTH))
                                                   : PtrW'(tail_sum);

  // expiry test on the head entry, wrap-safe age
  assign age    = now_q - rd_entry.stamp;
  assign expire = (count_q != '0) && (age > window_q);

  // admission decision
  assign sum_w        = CmpW'(total_q) + CmpW'(weight_q);
  assign over_limit   = sum_w > CmpW'(limit_q);
  assign log_full     = count_q >= CntW'(LOG_DEPTH);
  assign admit        = !over_limit && !log_full;
  assign result_total = admit ? sum_w : CmpW'(total_q);
  assign shown        = (result_total > CmpW'(swwl_pkg::ShownMax)) ? swwl_pkg::ShownMax
                                                                   : result_total[13:0];
  assign out_free     = !out_valid_q || m_axis_tready;

  always_comb begin
    priority if (over_limit) begin
      status = swwl_pkg::StatusOverLimit;
    end else if (log_full) begin
      status = swwl_pkg::StatusLogFull;
    end else begin
      status = swwl_pkg::StatusAccepted;
    end
  end

  // controller
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    wr_req.en    = 1'b0;
    wr_req.entry = '{stamp: now_q, weight: weight_q};
    unique case (state_q)
      swwl_pkg::StIdle: begin
        if (in_req) begin
          state_d = swwl_pkg::StCheck;
        end
      end
      swwl_pkg::StCheck: begin
        if (expire) begin
          // drop the head entry and look at the next one
          head_d  = (head_q == LastIdx) ? '0 : head_q + PtrW'(1);
          count_d = count_q - CntW'(1);
          total_d = total_q - TotalW'(rd_entry.weight);
        end else if (out_free) begin
          // decide, log when admitted, and load the result
          if (admit) begin
            wr_req.en = 1'b1;
            count_d   = count_q + CntW'(1);
            total_d   = TotalW'(sum_w);
          end
          out_valid_d = 1'b1;
          out_data_d  = {{(swwl_pkg::OutDataW - swwl_pkg::ShownW - swwl_pkg::StatusW
                           - 1){1'b0}}, shown, status, admit};
          state_d     = swwl_pkg::StIdle;
        end
      end
      default: begin
        state_d = swwl_pkg::StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swwl_pkg::StIdle;
      head_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= swwl_pkg::LimitReset;
      window_q <= swwl_pkg::WindowReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == swwl_pkg::CfgWeightLimit) begin
        limit_q <= cfg_data_i[swwl_pkg::LimitW-1:0];
      end
      if (cfg_index_i == swwl_pkg::CfgWindowTicks) begin
        window_q <= cfg_data_i;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      now_q    <= s_axis_tdata[swwl_pkg::TimeW-1:0];
      weight_q <= s_axis_tdata[swwl_pkg::TimeW +: swwl_pkg::WeightW];
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // log occupancy never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(LOG_DEPTH))
    else $error("log count above depth");

  // an empty log carries no weight
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (total_q == '0))
    else $error("total nonzero with empty log");

  // accepted flag agrees with the status code
  a_flag_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] ==
                       (m_axis_tdata[2:1] == swwl_pkg::StatusAccepted)))
    else $error("accepted flag and status disagree");

  // a taken request always moves into the check step
  a_req_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> (state_q == swwl_pkg::StCheck))
    else $error("request taken without check step");

endmodule

// File: verif/tb_sliding_window_weight_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_weight_limiter: self-checking bench of the weight limiter
// Drives weighted, timestamped requests over the slave stream and register
// writes over the config channel. A scoreboard class keeps its own copy of the
// ring log and predicts every verdict, which is checked field by field
// against the master stream. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

localparam int unsigned RingDepth = 64;

// register indexes that the block must ignore
localparam logic [swwl_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
localparam logic [swwl_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;

// one predicted verdict
typedef struct packed {
  logic                        accepted;
  swwl_pkg::status_e           status;
  logic [swwl_pkg::ShownW-1:0] window_total;
} verdict_t;

// predicts verdicts from its own copy of the log and checks results
class admit_scoreboard;
  logic [swwl_pkg::LimitW-1:0]  limit_q;
  logic [swwl_pkg::TimeW-1:0]   window_q;
  logic [swwl_pkg::WeightW-1:0] ring_weight [RingDepth];
  logic [swwl_pkg::TimeW-1:0]   ring_stamp  [RingDepth];
  int unsigned                  head_idx;
  int unsigned                  fill_cnt;
  int unsigned                  weight_sum;
  verdict_t                     pending_verdicts [$];
  int unsigned                  result_cnt;
  int unsigned                  error_cnt;

  function new();
    limit_q    = swwl_pkg::LimitReset;
    window_q   = swwl_pkg::WindowReset;
    head_idx   = 0;
    fill_cnt   = 0;
    weight_sum = 0;
    result_cnt = 0;
    error_cnt  = 0;
  endfunction

  function int unsigned pending();
    return pending_verdicts.size();
  endfunction

  function void apply_config(logic [swwl_pkg::CfgIdxW-1:0] idx,
                             logic [swwl_pkg::CfgDataW-1:0] data);
    case (idx)
      swwl_pkg::CfgWeightLimit: limit_q = data[swwl_pkg::LimitW-1:0];
      swwl_pkg::CfgWindowTicks: window_q = data[swwl_pkg::TimeW-1:0];
      default: ;
    endcase
  endfunction

  // an accepted request: expire, admit or refuse, queue the verdict
  function void note_request(logic [swwl_pkg::TimeW-1:0] now,
                             logic [swwl_pkg::WeightW-1:0] w);
    verdict_t    v;
    int unsigned tail;
    // drop head entries older than the window, wrap-safe age
    while (fill_cnt > 0 && (now - ring_stamp[head_idx]) > window_q) begin
      weight_sum = weight_sum - ring_weight[head_idx];
      head_idx   = (head_idx + 1) % RingDepth;
      fill_cnt   = fill_cnt - 1;
    end
    v.accepted = 1'b0;
    if (weight_sum + w > limit_q) begin
      v.status = swwl_pkg::StatusOverLimit;
    end else if (fill_cnt >= RingDepth) begin
      v.status = swwl_pkg::StatusLogFull;
    end else begin
      tail              = (head_idx + fill_cnt) % RingDepth;
      ring_weight[tail] = w;
      ring_stamp[tail]  = now;
      fill_cnt          = fill_cnt + 1;
      weight_sum        = weight_sum + w;
      v.status          = swwl_pkg::StatusAccepted;
      v.accepted        = 1'b1;
    end
    v.window_total = (weight_sum > swwl_pkg::ShownMax) ? swwl_pkg::ShownMax
                                                       : swwl_pkg::ShownW'(weight_sum);
    pending_verdicts.push_back(v);
  endfunction

  // an accepted result: compare with the oldest verdict
  function void check_result(logic [swwl_pkg::OutDataW-1:0] data);
    verdict_t v;
    result_cnt++;
    if (pending_verdicts.size() == 0) begin
      error_cnt++;
      if (error_cnt <= 10)
        $display("result %0d with no request outstanding, tdata %h", result_cnt, data);
      return;
    end
    v = pending_verdicts.pop_front();
    if (data[0] !== v.accepted || data[2:1] !== v.status ||
        data[16:3] !== v.window_total || data[swwl_pkg::OutDataW-1:17] !== '0) begin
      error_cnt++;
      if (error_cnt <= 10)
        $display("result %0d mismatch: accepted %0b/%0b status %0d/%0d total %0d/%0d pad %h",
                 result_cnt, v.accepted, data[0], v.status, data[2:1],
                 v.window_total, data[16:3], data[swwl_pkg::OutDataW-1:17]);
    end
  endfunction
endclass

module tb_sliding_window_weight_limiter;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // [31:0] now_time, [39:32] weight
  logic [swwl_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [0] accepted, [2:1] status, [16:3] window_total, [23:17] zero
  logic [swwl_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [swwl_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [swwl_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit rx_long_hold = 1'b0;
  bit rx_hold_done = 1'b0;

  admit_scoreboard sb;

  sliding_window_weight_limiter #(
    .LOG_DEPTH(RingDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // observe handshakes with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tdata[swwl_pkg::TimeW-1:0],
                        s_axis_tdata[swwl_pkg::TimeW+swwl_pkg::WeightW-1:swwl_pkg::TimeW]);
      if (cfg_valid_i && cfg_ready_o) sb.apply_config(cfg_index_i, cfg_data_i);
    end
  end

  // result side: random stall bursts and one long hold-off
  initial begin
    int unsigned gap_len;
    forever begin
      @(posedge clk_i);
      if (rx_long_hold && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        gap_len = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one request, after an optional idle burst; valid stays high on return
  task automatic send_request(input logic [swwl_pkg::TimeW-1:0] stamp,
                              input logic [swwl_pkg::WeightW-1:0] w);
    int unsigned gap_len;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap_len = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, stamp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait until every verdict has been checked
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [swwl_pkg::CfgIdxW-1:0] idx,
                              input logic [swwl_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // next timestamp: mostly same tick or small steps, some jumps and rewinds
  function automatic logic [swwl_pkg::TimeW-1:0] next_stamp(
    logic [swwl_pkg::TimeW-1:0] t, logic [swwl_pkg::TimeW-1:0] win);
    int unsigned                pick;
    logic [swwl_pkg::TimeW-1:0] span;
    pick = $urandom_range(0, 99);
    span = (win >> 3) + 1;
    if (pick < 30)      return t;
    else if (pick < 85) return t + $urandom_range(0, span);
    else if (pick < 94) return t + $urandom_range(0, win);
    else if (pick < 97) return $urandom();
    else                return t - $urandom_range(1, 16);
  endfunction

  // generous overall limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    logic [swwl_pkg::TimeW-1:0]   now_t;
    logic [swwl_pkg::LimitW-1:0]  limit_v;
    logic [swwl_pkg::TimeW-1:0]   window_v;
    logic [swwl_pkg::WeightW-1:0] w;
    int unsigned                  wmax;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: limit 100, window 60
    send_request(32'h0000_0000, 8'd0);
    send_request(32'h0000_0000, 8'd100);
    // entry exactly one window old stays
    send_request(32'h0000_003C, 8'd1);
    send_request(32'h0000_003D, 8'd1);
    send_request(32'h0000_003D, 8'd255);
    // time going backward expires the log
    send_request(32'h0000_0005, 8'd50);
    send_request(32'hFFFF_FFF0, 8'd10);
    send_request(32'hFFFF_FFFF, 8'd255);
    // wrap of the timestamp keeps the entry young
    send_request(32'h0000_0010, 8'd90);

    // limit lowered below the current total
    drain_results();
    write_config(swwl_pkg::CfgWeightLimit, 32'd10);
    send_request(32'h0000_0020, 8'd0);
    send_request(32'h0000_0060, 8'd10);

    // window of zero keeps only same-tick entries
    drain_results();
    write_config(swwl_pkg::CfgWindowTicks, 32'd0);
    write_config(swwl_pkg::CfgWeightLimit, 32'h0000_FFFF);
    send_request(32'h0000_0100, 8'd255);
    send_request(32'h0000_0100, 8'd255);
    send_request(32'h0000_0101, 8'd1);

    // spare indexes are ignored, zero limit still admits zero weight
    drain_results();
    write_config(CfgSpareLo, 32'hFFFF_FFFF);
    write_config(CfgSpareHi, 32'h0000_0001);
    write_config(swwl_pkg::CfgWeightLimit, 32'd0);
    send_request(32'h0000_0200, 8'd0);
    send_request(32'h0000_0200, 8'd1);

    // fill the log with an endless window
    drain_results();
    write_config(swwl_pkg::CfgWeightLimit, 32'h0000_FFFF);
    write_config(swwl_pkg::CfgWindowTicks, 32'hFFFF_FFFF);
    now_t = 32'h0000_0300;
    for (int k = 0; k < 66; k++) begin
      now_t = now_t + $urandom_range(0, 2);
      send_request(now_t, 8'($urandom_range(0, 3)));
    end
    // full log and over limit at once: over limit wins
    drain_results();
    write_config(swwl_pkg::CfgWeightLimit, 32'd0);
    send_request(now_t, 8'd1);
    drain_results();
    write_config(swwl_pkg::CfgWeightLimit, 32'h0000_FFFF);
    send_request(now_t, 8'd0);
    // short window, far step: the whole log expires on one request
    drain_results();
    write_config(swwl_pkg::CfgWindowTicks, 32'd10);
    send_request(now_t + 32'd1000, 8'd7);

    // random phases
    for (int p = 0; p < 9; p++) begin
      drain_results();
      if (p == 0) begin
        limit_v  = '0;
        window_v = 32'd1;
      end else if (p == 1) begin
        limit_v  = '1;
        window_v = '1;
      end else begin
        case ($urandom_range(0, 3))
          0:       limit_v = '0;
          1:       limit_v = '1;
          2:       limit_v = swwl_pkg::LimitReset;
          default: limit_v = swwl_pkg::LimitW'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(0, 4))
          0:       window_v = '0;
          1:       window_v = 32'd1;
          2:       window_v = '1;
          3:       window_v = $urandom_range(2, 1000);
          default: window_v = $urandom();
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        write_config($urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo, $urandom());
      // upper bits of the limit write are dropped by the block
      write_config(swwl_pkg::CfgWeightLimit, {16'($urandom()), limit_v});
      write_config(swwl_pkg::CfgWindowTicks, window_v);
      case ($urandom_range(0, 2))
        0:       wmax = 255;
        1:       wmax = 31;
        default: wmax = 3;
      endcase
      // long result hold-off while requests keep coming
      if (p == 3) rx_long_hold = 1'b1;
      // quiet tail of the run
      if (p == 8) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      now_t = $urandom();
      for (int k = 0; k < 50; k++) begin
        now_t = next_stamp(now_t, window_v);
        case ($urandom_range(0, 15))
          0:       w = '0;
          1:       w = '1;
          default: w = swwl_pkg::WeightW'($urandom_range(0, wmax));
        endcase
        send_request(now_t, w);
      end
    end

    drain_results();
    repeat (80) @(posedge clk_i);
    if (sb.error_cnt == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
